// File: hw/rtl/ordered_array_table_engine_macros.svh
// ----------------------------------------------------------------------------
// ordered array table engine assertion macros
// shared concurrent assertion forms for the table engine
// ----------------------------------------------------------------------------
`ifndef ORDERED_ARRAY_TABLE_ENGINE_MACROS_SVH
`define ORDERED_ARRAY_TABLE_ENGINE_MACROS_SVH

// same-cycle implication, disabled in reset
`define OATE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define OATE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/oate_pkg.sv
// ----------------------------------------------------------------------------
// oate_pkg
// types, sizes and codes shared by the ordered array table engine
// ----------------------------------------------------------------------------
package oate_pkg;

   // storage sizes
   localparam int MAX_ENTRIES = 16;
   localparam int WORD_BITS   = 32;
   localparam int ADDR_W      = $clog2(MAX_ENTRIES);
   localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);

   // field widths of a command and a response word
   localparam int ACTION_W = 3;
   localparam int SLOT_W   = 5;
   localparam int POS_W    = 4;
   localparam int STATUS_W = 2;
   localparam int LIMIT_W  = 5;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_ENTRIES);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

   // register index in the csr space
   localparam logic [0:0] REG_CAPACITY_LIMIT = 1'b0;

   typedef enum logic [ACTION_W-1:0] {
      ACT_GET    = 3'd0,
      ACT_SET    = 3'd1,
      ACT_APPEND = 3'd2,
      ACT_SEARCH = 3'd3,
      ACT_REMOVE = 3'd4,
      ACT_INSERT = 3'd5
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2,
      ST_MISS  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_GET_WAIT,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_RM_RD,
      S_RM_WR,
      S_INS_RD,
      S_INS_WR,
      S_DONE
   } state_type;

endpackage

// File: hw/rtl/oate_chan_if.sv
// ----------------------------------------------------------------------------
// oate channel interfaces
// valid/ready channels for command words and response words
// ----------------------------------------------------------------------------
interface oate_req_if;
   logic                                valid;
   logic                                ready;
   logic [oate_pkg::ACTION_W-1:0]       action;
   logic [oate_pkg::SLOT_W-1:0]         slot_index;
   logic signed [oate_pkg::WORD_BITS-1:0] data_word;

   modport source (output valid, action, slot_index, data_word, input ready);
   modport sink   (input valid, action, slot_index, data_word, output ready);
endinterface

interface oate_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [oate_pkg::WORD_BITS-1:0] read_word;
   logic [oate_pkg::POS_W-1:0]          found_position;
   logic [oate_pkg::COUNT_W-1:0]        entry_count;
   logic [oate_pkg::STATUS_W-1:0]       status;

   modport source (output valid, read_word, found_position, entry_count, status,
                   input ready);
   modport sink   (input valid, read_word, found_position, entry_count, status,
                   output ready);
endinterface

// File: hw/rtl/ordered_array_table_engine.sv
// operations: get reads a slot, set and append write one entry, search
//   compares from slot 0 up, remove moves entries down, insert moves them up
// throughput: one command at a time; the next word is taken in the cycle
//   after the response is taken, since one memory read port serves every move
// reset: occupancy 0, capacity limit 16; the entry store is not cleared
// ----------------------------------------------------------------------------
// ordered array table engine
// packed list of signed words with get, set, append, search, remove, insert
// driven by a small sequencer over one memory read port and one compare unit
// ----------------------------------------------------------------------------
`include "ordered_array_table_engine_macros.svh"

module ordered_array_table_engine (
   input  logic                               clock,
   input  logic                               reset,
   oate_req_if.sink                           req_chan,
   oate_rsp_if.source                         rsp_chan,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [oate_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [oate_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [oate_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   // entry store
   logic [oate_pkg::WORD_BITS-1:0] mem [oate_pkg::MAX_ENTRIES];

   oate_pkg::state_type                   state_ff, state_in;
   logic [oate_pkg::ACTION_W-1:0]         act_ff;
   logic [oate_pkg::SLOT_W-1:0]           slot_ff;
   logic [oate_pkg::WORD_BITS-1:0]        word_ff;
   logic [oate_pkg::COUNT_W-1:0]          occ_ff, occ_in;
   logic [oate_pkg::LIMIT_W-1:0]          limit_ff;
   logic [oate_pkg::COUNT_W-1:0]          ptr_ff, ptr_in;
   logic [oate_pkg::WORD_BITS-1:0]        rd_data_ff;
   logic [oate_pkg::WORD_BITS-1:0]        rsp_word_ff, rsp_word_in;
   logic [oate_pkg::POS_W-1:0]            rsp_pos_ff, rsp_pos_in;
   logic [oate_pkg::STATUS_W-1:0]         rsp_status_ff, rsp_status_in;

   logic                                  accept;
   logic                                  cfg_write;
   logic [oate_pkg::COUNT_W-1:0]          eff_limit;
   logic                                  is_full;
   logic [oate_pkg::COUNT_W-1:0]          ptr_plus, ptr_minus;
   logic                                  word_match;
   logic [oate_pkg::ADDR_W-1:0]           rd_addr;
   logic                                  mem_we;
   logic [oate_pkg::ADDR_W-1:0]           mem_wa;
   logic [oate_pkg::WORD_BITS-1:0]        mem_wd;

   assign accept    = req_chan.valid && req_chan.ready;
   assign cfg_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // csr read and ready
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == oate_pkg::REG_CAPACITY_LIMIT)
                     ? oate_pkg::CSR_DATA_W'(limit_ff) : '0;

   // limit above the store size saturates
   assign eff_limit = (limit_ff > oate_pkg::LIMIT_W'(oate_pkg::MAX_ENTRIES))
                    ? oate_pkg::MAX_COUNT : oate_pkg::COUNT_W'(limit_ff);
   assign is_full   = occ_ff >= eff_limit;

   // shared pointer step and compare unit
   assign ptr_plus   = ptr_ff + oate_pkg::COUNT_W'(1);
   assign ptr_minus  = ptr_ff - oate_pkg::COUNT_W'(1);
   assign word_match = rd_data_ff == word_ff;

   // request ready and response port
   assign req_chan.ready          = state_ff == oate_pkg::S_IDLE;
   assign rsp_chan.valid          = state_ff == oate_pkg::S_DONE;
   assign rsp_chan.read_word      = rsp_word_ff;
   assign rsp_chan.found_position = rsp_pos_ff;
   assign rsp_chan.entry_count    = occ_ff;
   assign rsp_chan.status         = rsp_status_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= oate_pkg::S_IDLE;
         occ_ff   <= '0;
         limit_ff <= oate_pkg::LIMIT_RESET;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
         if (cfg_write && csr_paddr[2] == oate_pkg::REG_CAPACITY_LIMIT) begin
            limit_ff <= csr_pwdata[oate_pkg::LIMIT_W-1:0];
         end
      end
   end

   // command and response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff  <= req_chan.action;
         slot_ff <= req_chan.slot_index;
         word_ff <= req_chan.data_word;
      end
      ptr_ff        <= ptr_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_status_ff <= rsp_status_in;
   end

   // store write port and registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      occ_in        = occ_ff;
      ptr_in        = ptr_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_status_in = rsp_status_ff;
      rd_addr       = ptr_ff[oate_pkg::ADDR_W-1:0];
      mem_we        = 1'b0;
      mem_wa        = ptr_ff[oate_pkg::ADDR_W-1:0];
      mem_wd        = rd_data_ff;

      case (state_ff)
         oate_pkg::S_IDLE: begin
            if (accept) begin
               state_in = oate_pkg::S_EXEC;
            end
         end

         oate_pkg::S_EXEC: begin
            rsp_word_in   = '0;
            rsp_pos_in    = '0;
            rsp_status_in = oate_pkg::ST_OK;
            rd_addr       = slot_ff[oate_pkg::ADDR_W-1:0];
            state_in      = oate_pkg::S_DONE;
            case (act_ff)
               oate_pkg::ACT_GET: begin
                  if (oate_pkg::COUNT_W'(slot_ff) < occ_ff) begin
                     state_in = oate_pkg::S_GET_WAIT;
                  end else begin
                     rsp_status_in = oate_pkg::ST_RANGE;
                  end
               end
               oate_pkg::ACT_SET: begin
                  if (oate_pkg::COUNT_W'(slot_ff) < occ_ff) begin
                     mem_we = 1'b1;
                     mem_wa = slot_ff[oate_pkg::ADDR_W-1:0];
                     mem_wd = word_ff;
                  end else begin
                     rsp_status_in = oate_pkg::ST_RANGE;
                  end
               end
               oate_pkg::ACT_APPEND: begin
                  if (is_full) begin
                     rsp_status_in = oate_pkg::ST_FULL;
                  end else begin
                     mem_we = 1'b1;
                     mem_wa = occ_ff[oate_pkg::ADDR_W-1:0];
                     mem_wd = word_ff;
                     occ_in = occ_ff + oate_pkg::COUNT_W'(1);
                  end
               end
               oate_pkg::ACT_SEARCH: begin
                  ptr_in = '0;
                  if (occ_ff == '0) begin
                     rsp_status_in = oate_pkg::ST_MISS;
                  end else begin
                     state_in = oate_pkg::S_SRCH_RD;
                  end
               end
               oate_pkg::ACT_REMOVE: begin
                  ptr_in = oate_pkg::COUNT_W'(slot_ff);
                  if (oate_pkg::COUNT_W'(slot_ff) < occ_ff) begin
                     state_in = oate_pkg::S_RM_RD;
                  end else begin
                     rsp_status_in = oate_pkg::ST_RANGE;
                  end
               end
               oate_pkg::ACT_INSERT: begin
                  ptr_in = occ_ff;
                  if (oate_pkg::COUNT_W'(slot_ff) > occ_ff) begin
                     rsp_status_in = oate_pkg::ST_RANGE;
                  end else if (is_full) begin
                     rsp_status_in = oate_pkg::ST_FULL;
                  end else begin
                     state_in = oate_pkg::S_INS_RD;
                  end
               end
               default: begin
                  rsp_status_in = oate_pkg::ST_RANGE;
               end
            endcase
         end

         // read data from the slot is now registered
         oate_pkg::S_GET_WAIT: begin
            rsp_word_in = rd_data_ff;
            state_in    = oate_pkg::S_DONE;
         end

         // scan: fetch one entry, then compare it
         oate_pkg::S_SRCH_RD: begin
            state_in = oate_pkg::S_SRCH_CMP;
         end

         oate_pkg::S_SRCH_CMP: begin
            if (word_match) begin
               rsp_pos_in    = ptr_ff[oate_pkg::POS_W-1:0];
               rsp_status_in = oate_pkg::ST_OK;
               state_in      = oate_pkg::S_DONE;
            end else if (ptr_plus < occ_ff) begin
               ptr_in   = ptr_plus;
               state_in = oate_pkg::S_SRCH_RD;
            end else begin
               rsp_status_in = oate_pkg::ST_MISS;
               state_in      = oate_pkg::S_DONE;
            end
         end

         // remove: move the next entry down one place
         oate_pkg::S_RM_RD: begin
            rd_addr = ptr_plus[oate_pkg::ADDR_W-1:0];
            if (ptr_plus < occ_ff) begin
               state_in = oate_pkg::S_RM_WR;
            end else begin
               occ_in   = occ_ff - oate_pkg::COUNT_W'(1);
               state_in = oate_pkg::S_DONE;
            end
         end

         oate_pkg::S_RM_WR: begin
            mem_we   = 1'b1;
            ptr_in   = ptr_plus;
            state_in = oate_pkg::S_RM_RD;
         end

         // insert: move entries up until the gap reaches the slot
         oate_pkg::S_INS_RD: begin
            rd_addr = ptr_minus[oate_pkg::ADDR_W-1:0];
            if (ptr_ff > oate_pkg::COUNT_W'(slot_ff)) begin
               state_in = oate_pkg::S_INS_WR;
            end else begin
               mem_we   = 1'b1;
               mem_wa   = slot_ff[oate_pkg::ADDR_W-1:0];
               mem_wd   = word_ff;
               occ_in   = occ_ff + oate_pkg::COUNT_W'(1);
               state_in = oate_pkg::S_DONE;
            end
         end

         oate_pkg::S_INS_WR: begin
            mem_we   = 1'b1;
            ptr_in   = ptr_minus;
            state_in = oate_pkg::S_INS_RD;
         end

         oate_pkg::S_DONE: begin
            if (rsp_chan.ready) begin
               state_in = oate_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = oate_pkg::S_IDLE;
         end
      endcase
   end

   // checks
   `OATE_ASSERT_IMPL(a_occ_bound, clock, reset, 1'b1, occ_ff <= oate_pkg::MAX_COUNT, "occupancy above store size")
   `OATE_ASSERT_NEXT(a_idle_occ_hold, clock, reset, state_ff == oate_pkg::S_IDLE, occ_ff == $past(occ_ff), "occupancy moved while idle")
   `OATE_ASSERT_IMPL(a_full_reason, clock, reset, rsp_chan.valid && rsp_status_ff == oate_pkg::ST_FULL, occ_ff >= eff_limit, "full reported below limit")
   `OATE_ASSERT_IMPL(a_scan_in_range, clock, reset, state_ff == oate_pkg::S_SRCH_CMP || state_ff == oate_pkg::S_RM_WR, ptr_ff < occ_ff, "scan pointer past occupancy")

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: ordered array table engine testbench
// feeds get, set, append, search, remove and insert commands through the
// command channel under several capacity limits and idle/stall patterns,
// tracks the list contents in a local model and checks every response word
// field by field in order
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CYCLE_LIMIT = 600000;
   localparam logic [oate_pkg::CSR_ADDR_W-1:0] LIMIT_ADDR =
      oate_pkg::CSR_ADDR_W'(4 * oate_pkg::REG_CAPACITY_LIMIT);

   // action codes the engine does not implement
   localparam logic [oate_pkg::ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
   localparam logic [oate_pkg::ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [oate_pkg::ACTION_W-1:0]  action;
      logic [oate_pkg::SLOT_W-1:0]    slot_index;
      logic [oate_pkg::WORD_BITS-1:0] data_word;
   } cmd_type;

   typedef struct packed {
      logic [oate_pkg::WORD_BITS-1:0] read_word;
      logic [oate_pkg::POS_W-1:0]     found_position;
      logic [oate_pkg::COUNT_W-1:0]   entry_count;
      oate_pkg::status_type           status;
   } rsp_type;

   typedef struct packed {
      logic [oate_pkg::MAX_ENTRIES-1:0][oate_pkg::WORD_BITS-1:0] words;
      logic [oate_pkg::COUNT_W-1:0]                              count;
      logic [oate_pkg::LIMIT_W-1:0]                              limit;
   } list_type;

   logic clock = 1'b0;
   logic reset;

   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [oate_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [oate_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [oate_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   oate_req_if req_if();
   oate_rsp_if rsp_if();

   ordered_array_table_engine uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   cmd_type  cmd_queue[$];    // commands waiting to be driven
   rsp_type  due_rsps[$];     // responses owed by the engine, oldest first
   list_type list_state;      // list as seen by accepted commands
   list_type gen_state;       // list as seen by queued commands, steers stimulus
   int       src_idle_pct;
   int       rcv_stall_pct;
   int       fail_count;
   int       cycle_count;

   // apply one command to a list and return the response it produces
   function automatic rsp_type list_apply(inout list_type t, input cmd_type c);
      rsp_type r;
      int      eff;
      int      i;
      r = '0;
      r.status = oate_pkg::ST_OK;
      eff = (int'(t.limit) > oate_pkg::MAX_ENTRIES) ? oate_pkg::MAX_ENTRIES
                                                    : int'(t.limit);
      case (c.action)
         oate_pkg::ACT_GET: begin
            if (c.slot_index < t.count)
               r.read_word = t.words[c.slot_index[oate_pkg::ADDR_W-1:0]];
            else r.status = oate_pkg::ST_RANGE;
         end
         oate_pkg::ACT_SET: begin
            if (c.slot_index < t.count)
               t.words[c.slot_index[oate_pkg::ADDR_W-1:0]] = c.data_word;
            else r.status = oate_pkg::ST_RANGE;
         end
         oate_pkg::ACT_APPEND: begin
            if (int'(t.count) >= eff) begin
               r.status = oate_pkg::ST_FULL;
            end else begin
               t.words[t.count[oate_pkg::ADDR_W-1:0]] = c.data_word;
               t.count = t.count + 1'b1;
            end
         end
         oate_pkg::ACT_SEARCH: begin
            // scan downward so the lowest matching position wins
            r.status = oate_pkg::ST_MISS;
            for (i = int'(t.count) - 1; i >= 0; i--) begin
               if (t.words[oate_pkg::ADDR_W'(i)] == c.data_word) begin
                  r.found_position = oate_pkg::POS_W'(i);
                  r.status = oate_pkg::ST_OK;
               end
            end
         end
         oate_pkg::ACT_REMOVE: begin
            if (c.slot_index < t.count) begin
               for (i = int'(c.slot_index); i + 1 < int'(t.count); i++)
                  t.words[oate_pkg::ADDR_W'(i)] = t.words[oate_pkg::ADDR_W'(i + 1)];
               t.count = t.count - 1'b1;
            end else begin
               r.status = oate_pkg::ST_RANGE;
            end
         end
         oate_pkg::ACT_INSERT: begin
            // index is checked before fullness
            if (c.slot_index > t.count) begin
               r.status = oate_pkg::ST_RANGE;
            end else if (int'(t.count) >= eff) begin
               r.status = oate_pkg::ST_FULL;
            end else begin
               for (i = int'(t.count); i > int'(c.slot_index); i--)
                  t.words[oate_pkg::ADDR_W'(i)] = t.words[oate_pkg::ADDR_W'(i - 1)];
               t.words[c.slot_index[oate_pkg::ADDR_W-1:0]] = c.data_word;
               t.count = t.count + 1'b1;
            end
         end
         default: r.status = oate_pkg::ST_RANGE;
      endcase
      r.entry_count = t.count;
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      if (fail_count < 10)
         $display("mismatch %s: expected %h, got %h at %0t", what, want, got, $time);
      fail_count++;
   endtask

   task automatic queue_cmd(input logic [oate_pkg::ACTION_W-1:0] action,
                            input logic [oate_pkg::SLOT_W-1:0] slot,
                            input logic [oate_pkg::WORD_BITS-1:0] data);
      cmd_type c;
      c.action     = action;
      c.slot_index = slot;
      c.data_word  = data;
      void'(list_apply(gen_state, c));
      cmd_queue.push_back(c);
   endtask

   // a boundary value or a fully random one
   function automatic logic [oate_pkg::WORD_BITS-1:0] pick_word();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0000;
         4: return 32'h0000_0001;
         default: return $urandom;
      endcase
   endfunction

   // mostly well-formed commands around the current fill, some noise
   task automatic queue_random(input int n);
      logic [oate_pkg::ACTION_W-1:0]  act;
      logic [oate_pkg::SLOT_W-1:0]    slot;
      logic [oate_pkg::WORD_BITS-1:0] data;
      int                             roll;
      int                             cnt;
      repeat (n) begin
         cnt  = int'(gen_state.count);
         roll = $urandom_range(0, 99);
         if (roll < 3)       act = ($urandom_range(0, 1) != 0) ? ACT_SPARE_HI : ACT_SPARE_LO;
         else if (roll < 20) act = oate_pkg::ACT_APPEND;
         else if (roll < 33) act = oate_pkg::ACT_INSERT;
         else if (roll < 55) act = oate_pkg::ACT_REMOVE;
         else if (roll < 67) act = oate_pkg::ACT_GET;
         else if (roll < 79) act = oate_pkg::ACT_SET;
         else                act = oate_pkg::ACT_SEARCH;
         roll = $urandom_range(0, 99);
         if (roll < 8)        slot = oate_pkg::SLOT_W'($urandom);
         else if (roll < 16)  slot = oate_pkg::SLOT_W'(cnt);
         else if (cnt > 0)    slot = oate_pkg::SLOT_W'($urandom_range(0, cnt - 1));
         else                 slot = '0;
         if (cnt > 0 && $urandom_range(0, 99) < 40)
            data = gen_state.words[oate_pkg::ADDR_W'($urandom_range(0, cnt - 1))];
         else
            data = pick_word();
         queue_cmd(act, slot, data);
      end
   endtask

   // wait until every queued word is driven and answered, checked between edges
   task automatic drain();
      do @(negedge clock);
      while (cmd_queue.size() != 0 || req_if.valid || due_rsps.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // apb write of the capacity limit, engine idle
   task automatic write_limit(input logic [oate_pkg::LIMIT_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= LIMIT_ADDR;
      csr_pwdata  <= oate_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      list_state.limit = value;
      gen_state.limit  = value;
   endtask

   // command driver
   always @(posedge clock) begin : drive_cmds
      cmd_type c;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            c.action     = req_if.action;
            c.slot_index = req_if.slot_index;
            c.data_word  = req_if.data_word;
            due_rsps.push_back(list_apply(list_state, c));
         end
         if (!req_if.valid || req_if.ready) begin
            if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
               c = cmd_queue.pop_front();
               req_if.valid      <= 1'b1;
               req_if.action     <= c.action;
               req_if.slot_index <= c.slot_index;
               req_if.data_word  <= c.data_word;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // response checker
   always @(posedge clock) begin : check_rsps
      rsp_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (due_rsps.size() == 0) begin
               flag_mismatch("unexpected word, entry_count", '0, 32'(rsp_if.entry_count));
            end else begin
               want = due_rsps.pop_front();
               if (rsp_if.read_word !== want.read_word)
                  flag_mismatch("read_word", want.read_word, rsp_if.read_word);
               if (rsp_if.found_position !== want.found_position)
                  flag_mismatch("found_position", 32'(want.found_position),
                                32'(rsp_if.found_position));
               if (rsp_if.entry_count !== want.entry_count)
                  flag_mismatch("entry_count", 32'(want.entry_count),
                                32'(rsp_if.entry_count));
               if (rsp_if.status !== want.status)
                  flag_mismatch("status", 32'(want.status), 32'(rsp_if.status));
            end
         end
         rsp_if.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.action     = '0;
      req_if.slot_index = '0;
      req_if.data_word  = '0;
      rsp_if.ready      = 1'b0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      src_idle_pct      = 0;
      rcv_stall_pct     = 0;
      fail_count        = 0;
      cycle_count       = 0;
      list_state        = '0;
      list_state.limit  = oate_pkg::LIMIT_RESET;
      gen_state         = list_state;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: empty list, edges of the index range, duplicates, spare codes
      write_limit(5'd16);
      queue_cmd(oate_pkg::ACT_GET,    5'd0,  32'h0);
      queue_cmd(oate_pkg::ACT_REMOVE, 5'd0,  32'h0);
      queue_cmd(oate_pkg::ACT_SEARCH, 5'd0,  32'h0);
      queue_cmd(oate_pkg::ACT_SET,    5'd0,  32'h1);
      queue_cmd(oate_pkg::ACT_INSERT, 5'd1,  32'h1);
      queue_cmd(oate_pkg::ACT_INSERT, 5'd0,  32'h7FFF_FFFF);
      queue_cmd(oate_pkg::ACT_APPEND, 5'd0,  32'h8000_0000);
      queue_cmd(oate_pkg::ACT_APPEND, 5'd31, 32'hFFFF_FFFF);
      queue_cmd(oate_pkg::ACT_INSERT, 5'd3,  32'h0);
      queue_cmd(oate_pkg::ACT_INSERT, 5'd1,  32'h1234_5678);
      queue_cmd(oate_pkg::ACT_GET,    5'd0,  32'h0);
      queue_cmd(oate_pkg::ACT_GET,    5'd4,  32'h0);
      queue_cmd(oate_pkg::ACT_GET,    5'd5,  32'h0);
      queue_cmd(oate_pkg::ACT_GET,    5'd31, 32'h0);
      queue_cmd(oate_pkg::ACT_SET,    5'd2,  32'h5555_5555);
      queue_cmd(oate_pkg::ACT_SEARCH, 5'd0,  32'hFFFF_FFFF);
      queue_cmd(oate_pkg::ACT_APPEND, 5'd0,  32'h7FFF_FFFF);
      queue_cmd(oate_pkg::ACT_SEARCH, 5'd0,  32'h7FFF_FFFF);
      queue_cmd(oate_pkg::ACT_SEARCH, 5'd0,  32'h2468_ACE1);
      queue_cmd(oate_pkg::ACT_REMOVE, 5'd5,  32'h0);
      queue_cmd(oate_pkg::ACT_REMOVE, 5'd0,  32'h0);
      queue_cmd(oate_pkg::ACT_REMOVE, 5'd31, 32'h0);
      queue_cmd(ACT_SPARE_LO, 5'd0,  32'h0);
      queue_cmd(ACT_SPARE_HI, 5'd31, 32'hFFFF_FFFF);
      queue_cmd(oate_pkg::ACT_INSERT, 5'd4,  32'hAAAA_AAAA);
      drain();

      // limit above the table size saturates; fill to the top and overflow
      write_limit(5'd31);
      queue_random(220);
      while (gen_state.count < oate_pkg::MAX_COUNT)
         queue_cmd(oate_pkg::ACT_APPEND, 5'd0, pick_word());
      queue_cmd(oate_pkg::ACT_APPEND, 5'd0,  pick_word());
      queue_cmd(oate_pkg::ACT_INSERT, 5'd0,  pick_word());
      queue_cmd(oate_pkg::ACT_INSERT, 5'd17, pick_word());
      drain();

      // limit dropped below the fill, sender idling
      src_idle_pct = 56;
      write_limit(5'd3);
      queue_random(200);
      drain();

      // zero limit: always full, receiver stalling
      src_idle_pct  = 0;
      rcv_stall_pct = 56;
      write_limit(5'd0);
      queue_random(40);
      drain();

      // single entry, both sides pausing
      src_idle_pct  = 11;
      rcv_stall_pct = 11;
      write_limit(5'd1);
      queue_random(60);
      drain();

      src_idle_pct  = 0;
      rcv_stall_pct = 56;
      write_limit(5'd16);
      queue_random(220);
      drain();

      src_idle_pct  = 11;
      rcv_stall_pct = 11;
      write_limit(5'd9);
      queue_random(200);
      drain();

      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
